// File: hw/rtl/mtcs_pkg.sv
// Shared constants, types, cosine table and helper functions of the multi-tone synthesizer.
package mtcs_pkg;

  localparam int MAX_TONES      = 8;
  localparam int COS_TABLE_BITS = 10;
  localparam int PHASE_BITS     = 32;

  localparam int OP_W       = 2;
  localparam int IDX_W      = 3;
  localparam int AMP_W      = 24;
  localparam int IN_PHASE_W = 32;
  localparam int CNT_W      = 4;
  localparam int OUT_W      = 19;
  localparam int COS_W      = 16;
  localparam int FRAC_BITS  = 23;

  localparam int TONE_W  = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
  localparam int CMP_W   = ((TONE_W > CNT_W) ? TONE_W : CNT_W) + 1;
  localparam int PROD_W  = AMP_W + COS_W;
  localparam int SUM_W   = PROD_W + $clog2(MAX_TONES) + 4;
  localparam int QUO_W   = SUM_W - FRAC_BITS;

  localparam int TABLE_LEN = 1 << COS_TABLE_BITS;
  localparam int HALF_LEN  = TABLE_LEN / 2;
  localparam int QTR_LEN   = TABLE_LEN / 4;
  localparam int QTR_BITS  = COS_TABLE_BITS - 2;
  localparam int ADDR_W    = COS_TABLE_BITS + 1;

  localparam longint unsigned PI_Q30  = 64'd3373259425;
  localparam longint unsigned ONE_Q30 = 64'd1 << 30;

  // Divisors (2n - 1) * 2n of the Taylor series terms, n from 1 to 10.
  localparam longint unsigned TAYLOR_DIV [10] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
                                                  64'd132, 64'd182, 64'd240, 64'd306, 64'd380};

  localparam int OUT_MAX = 262143;
  localparam int OUT_MIN = -262144;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD    = 2'd0,
    OP_SAMPLE  = 2'd1,
    OP_RESTART = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic signed [AMP_W-1:0] amp;
    logic [PHASE_BITS-1:0]   step;
    logic [PHASE_BITS-1:0]   offset;
  } tone_cfg_t;

  typedef struct packed {
    tone_cfg_t             cfg;
    logic [PHASE_BITS-1:0] acc;
  } tone_rec_t;

  typedef struct packed {
    logic shift;
    logic restart;
  } cell_ctl_t;

  typedef struct packed {
    logic start;
    logic step;
    logic active;
  } head_ctl_t;

  typedef logic signed [COS_W-1:0] qtab_t [QTR_LEN];

  function automatic longint unsigned qcos_q30(longint unsigned theta);
    longint unsigned x2;
    longint unsigned term;
    longint          acc;
    x2   = (theta * theta) >> 30;
    term = ONE_Q30;
    acc  = longint'(ONE_Q30);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
      if ((n % 2) == 1) begin
        acc = acc - longint'(term);
      end else begin
        acc = acc + longint'(term);
      end
    end
    return (acc < 0) ? 64'd0 : longint'(unsigned'(acc));
  endfunction

  function automatic logic signed [COS_W-1:0] cos_entry(int r);
    longint unsigned theta;
    longint unsigned c;
    longint unsigned q15;
    theta = (longint'(unsigned'(r)) * PI_Q30) >> (COS_TABLE_BITS - 1);
    c     = qcos_q30(theta);
    q15   = (c + (ONE_Q30 >> 16)) >> 15;
    if (q15 > 64'd32767) begin
      q15 = 64'd32767;
    end
    return COS_W'(q15);
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int r = 0; r < QTR_LEN; r++) begin
      t[r] = cos_entry(r);
    end
    return t;
  endfunction

  localparam qtab_t COS_QTAB = build_qtab();
  localparam logic signed [COS_W-1:0] COS_QEND = cos_entry(QTR_LEN);

  function automatic logic signed [COS_W-1:0] cos_lookup(logic [COS_TABLE_BITS-1:0] addr);
    logic [ADDR_W-1:0]       r;
    logic                    neg;
    logic signed [COS_W-1:0] v;
    if (addr <= COS_TABLE_BITS'(HALF_LEN)) begin
      r = {1'b0, addr};
    end else begin
      r = ADDR_W'(TABLE_LEN) - {1'b0, addr};
    end
    neg = (r > ADDR_W'(QTR_LEN));
    if (neg) begin
      r = ADDR_W'(HALF_LEN) - r;
    end
    if (r == ADDR_W'(QTR_LEN)) begin
      v = COS_QEND;
    end else begin
      v = COS_QTAB[r[QTR_BITS-1:0]];
    end
    return neg ? -v : v;
  endfunction

  function automatic logic [PHASE_BITS-1:0] align_phase(logic [IN_PHASE_W-1:0] v);
    logic [IN_PHASE_W+15:0] t;
    t = {v, 16'd0};
    return t[IN_PHASE_W+15 -: PHASE_BITS];
  endfunction

endpackage

// File: hw/rtl/mtcs_ifs.sv
// Request channel interfaces for the input, result and configuration ports.
interface mtcs_in_if;
  logic                              valid;
  logic                              ready;
  logic [mtcs_pkg::OP_W-1:0]         operation;
  logic [mtcs_pkg::IDX_W-1:0]        tone_index;
  logic signed [mtcs_pkg::AMP_W-1:0] amplitude;
  logic [mtcs_pkg::IN_PHASE_W-1:0]   freq_step;
  logic [mtcs_pkg::IN_PHASE_W-1:0]   phase_offset;

  modport source (output valid, operation, tone_index, amplitude, freq_step, phase_offset,
                  input ready);
  modport sink (input valid, operation, tone_index, amplitude, freq_step, phase_offset,
                output ready);
endinterface

interface mtcs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [mtcs_pkg::OUT_W-1:0] sample;

  modport source (output valid, sample, input ready);
  modport sink (input valid, sample, output ready);
endinterface

interface mtcs_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mtcs_pkg::CNT_W-1:0] tone_count;

  modport source (output valid, tone_count, input ready);
  modport sink (input valid, tone_count, output ready);
endinterface

// File: hw/rtl/multi_tone_cosine_synthesizer_unit.sv
// Top level of the multi-tone cosine synthesizer with its request handling.
// Tones live in a ring of cells, one tone per cell. A load request writes one cell and a
// restart request clears every phase accumulator. A sample request rotates the ring once,
// presenting one tone per cycle to a shared head that looks up the cosine, multiplies by
// the amplitude and accumulates, and advances the accumulators of the first tone_count
// tones. After the three-stage head pipeline drains, the sum is scaled, saturated and
// placed in the output register. A new request is taken while a finished sample still
// waits in the output register.
module multi_tone_cosine_synthesizer_unit (
  input logic        clk,
  input logic        rst_n,
  mtcs_in_if.sink    in_ch,
  mtcs_out_if.source out_ch,
  mtcs_cfg_if.sink   cfg_ch
);
  import mtcs_pkg::*;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [TONE_W-1:0]       k_r;
  logic [TONE_W-1:0]       k_nxt;
  logic [CNT_W-1:0]        tone_count_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [OUT_W-1:0] out_sample_r;

  logic                    in_fire;
  logic                    run_last;
  logic                    out_load;
  logic                    load_go;
  logic                    head_busy;
  logic signed [OUT_W-1:0] head_sample;
  head_ctl_t               head_ctl;
  cell_ctl_t               cell_ctl;
  tone_cfg_t               load_cfg;
  tone_rec_t               rec [MAX_TONES];
  tone_rec_t               wrap_rec;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire  = in_ch.valid & in_ch.ready;
  assign run_last = (k_r == TONE_W'(MAX_TONES - 1));
  assign load_cfg = '{amp:    in_ch.amplitude,
                      step:   align_phase(in_ch.freq_step),
                      offset: align_phase(in_ch.phase_offset)};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_ch.operation == OP_SAMPLE)) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (run_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    head_ctl.start   = 1'b0;
    head_ctl.step    = 1'b0;
    head_ctl.active  = (CMP_W'(k_r) < CMP_W'(tone_count_r));
    cell_ctl.shift   = 1'b0;
    cell_ctl.restart = 1'b0;
    load_go          = 1'b0;
    out_load         = 1'b0;
    k_nxt            = '0;
    unique case (state_r)
      ST_IDLE: begin
        head_ctl.start   = in_fire && (in_ch.operation == OP_SAMPLE);
        cell_ctl.restart = in_fire && (in_ch.operation == OP_RESTART);
        load_go          = in_fire && (in_ch.operation == OP_LOAD);
      end
      ST_RUN: begin
        head_ctl.step  = 1'b1;
        cell_ctl.shift = 1'b1;
        k_nxt          = k_r + TONE_W'(1);
      end
      ST_DRAIN: begin
        out_load = !head_busy && (!out_valid_r || out_ch.ready);
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      k_r          <= '0;
      tone_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        tone_count_r <= cfg_ch.tone_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_sample_r <= head_sample;
    end
  end

  assign cfg_ch.ready  = 1'b1;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.sample = out_sample_r;

  for (genvar i = 0; i < MAX_TONES; i++) begin : g_cell
    tone_rec_t shift_in;
    logic      load_en;

    if (i == MAX_TONES - 1) begin : g_tail
      assign shift_in = wrap_rec;
    end else begin : g_mid
      assign shift_in = rec[i+1];
    end

    assign load_en = load_go &&
                     ({{(CMP_W-IDX_W){1'b0}}, in_ch.tone_index} == CMP_W'(i));

    mtcs_tone_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl),
      .load_en  (load_en),
      .load_cfg (load_cfg),
      .shift_in (shift_in),
      .rec      (rec[i])
    );
  end

  mtcs_head u_head (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (head_ctl),
    .head_rec (rec[0]),
    .wrap_rec (wrap_rec),
    .busy     (head_busy),
    .sample   (head_sample)
  );

endmodule

// File: hw/rtl/mtcs_tone_cell.sv
// One ring cell holding a tone's amplitude, step, offset and phase accumulator.
module mtcs_tone_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  mtcs_pkg::cell_ctl_t ctl,
  input  logic                load_en,
  input  mtcs_pkg::tone_cfg_t load_cfg,
  input  mtcs_pkg::tone_rec_t shift_in,
  output mtcs_pkg::tone_rec_t rec
);
  import mtcs_pkg::*;

  tone_cfg_t             cfg_r;
  tone_cfg_t             cfg_nxt;
  logic [PHASE_BITS-1:0] acc_r;
  logic [PHASE_BITS-1:0] acc_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    acc_nxt = acc_r;
    if (ctl.shift) begin
      cfg_nxt = shift_in.cfg;
      acc_nxt = shift_in.acc;
    end
    if (load_en) begin
      cfg_nxt = load_cfg;
    end
    if (ctl.restart) begin
      acc_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    cfg_r <= cfg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign rec = '{cfg: cfg_r, acc: acc_r};

endmodule

// File: hw/rtl/mtcs_head.sv
// Ring head: cosine lookup, multiply-accumulate pipeline, accumulator advance and output scaling.
module mtcs_head (
  input  logic                               clk,
  input  logic                               rst_n,
  input  mtcs_pkg::head_ctl_t                ctl,
  input  mtcs_pkg::tone_rec_t                head_rec,
  output mtcs_pkg::tone_rec_t                wrap_rec,
  output logic                               busy,
  output logic signed [mtcs_pkg::OUT_W-1:0]  sample
);
  import mtcs_pkg::*;

  localparam logic signed [QUO_W-1:0] QUO_MAX = QUO_W'(OUT_MAX);
  localparam logic signed [QUO_W-1:0] QUO_MIN = QUO_W'(OUT_MIN);

  logic [PHASE_BITS-1:0]    phase;
  logic signed [COS_W-1:0]  cos_val;
  logic signed [COS_W-1:0]  cos_r;
  logic signed [AMP_W-1:0]  amp_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic                     v1_r;
  logic                     v2_r;
  logic signed [SUM_W-1:0]  sum_adj;
  logic signed [QUO_W-1:0]  quo;

  assign phase   = head_rec.acc + head_rec.cfg.offset;
  assign cos_val = cos_lookup(phase[PHASE_BITS-1 -: COS_TABLE_BITS]);

  always_comb begin
    wrap_rec     = head_rec;
    wrap_rec.acc = head_rec.acc + (ctl.active ? head_rec.cfg.step : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= ctl.step;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    cos_r  <= ctl.active ? cos_val : '0;
    amp_r  <= ctl.active ? head_rec.cfg.amp : '0;
    prod_r <= amp_r * cos_r;
    if (ctl.start) begin
      sum_r <= '0;
    end else if (v2_r) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end
  end

  assign busy = v1_r | v2_r;

  // Division by 2^23 rounds toward zero, so negative sums are biased first.
  assign sum_adj = sum_r + $signed({{(SUM_W-FRAC_BITS){1'b0}}, {FRAC_BITS{sum_r[SUM_W-1]}}});
  assign quo     = sum_adj[SUM_W-1:FRAC_BITS];

  always_comb begin
    if (quo > QUO_MAX) begin
      sample = OUT_W'(OUT_MAX);
    end else if (quo < QUO_MIN) begin
      sample = OUT_W'(OUT_MIN);
    end else begin
      sample = quo[OUT_W-1:0];
    end
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking regression of the multi-tone cosine synthesizer with its own sample predictor.
module tb;
  import mtcs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = MAX_TONES + 12;
  localparam int STALL_LIMIT = 4000;
  localparam int NUM_PHASES = 14;
  localparam int RANDOM_REQS = 1470;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        idx;
    logic signed [AMP_W-1:0] amp;
    logic [IN_PHASE_W-1:0]   step;
    logic [IN_PHASE_W-1:0]   offset;
  } tone_req_t;

  logic clk;
  logic rst_n;

  mtcs_in_if  in_if ();
  mtcs_out_if out_if ();
  mtcs_cfg_if cfg_if ();

  multi_tone_cosine_synthesizer_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  int wave_rom [TABLE_LEN];
  logic [PHASE_BITS-1:0]   ph_acc [MAX_TONES];
  logic signed [AMP_W-1:0] gain [MAX_TONES];
  logic [PHASE_BITS-1:0]   incr [MAX_TONES];
  logic [PHASE_BITS-1:0]   offs [MAX_TONES];
  logic [CNT_W-1:0]        tones_enabled;

  tone_req_t pending_reqs [$];
  logic signed [OUT_W-1:0] expected_samples [$];

  int in_gap_pct;
  int out_stall_pct;
  int error_count;
  int reqs_accepted;
  int samples_checked;
  int settings_written;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint quarter_cosine(longint unsigned ang);
    longint unsigned sq;
    longint unsigned term;
    longint unsigned n;
    longint          total;
    sq    = (ang * ang) >> 30;
    term  = 64'd1 << 30;
    total = longint'(64'd1 << 30);
    for (n = 1; n <= 10; n++) begin
      term = ((term * sq) >> 30) / ((2 * n - 1) * (2 * n));
      if (n[0]) begin
        total = total - longint'(term);
      end else begin
        total = total + longint'(term);
      end
    end
    return (total < 0) ? 64'sd0 : total;
  endfunction

  function automatic void fill_wave_rom();
    int              r;
    bit              neg;
    longint unsigned ang;
    longint          q;
    for (int k = 0; k < TABLE_LEN; k++) begin
      r   = (k <= HALF_LEN) ? k : TABLE_LEN - k;
      neg = (r > QTR_LEN);
      if (neg) begin
        r = HALF_LEN - r;
      end
      ang = (longint'(unsigned'(r)) * PI_Q30) >> (COS_TABLE_BITS - 1);
      q   = (quarter_cosine(ang) + 64'sd16384) >>> 15;
      if (q > 32767) begin
        q = 32767;
      end
      wave_rom[k] = neg ? -int'(q) : int'(q);
    end
  endfunction

  function automatic logic [PHASE_BITS-1:0] to_phase(logic [IN_PHASE_W-1:0] v);
    logic [63:0] w;
    w = {16'd0, v, 16'd0} >> (48 - PHASE_BITS);
    return w[PHASE_BITS-1:0];
  endfunction

  // Applies one accepted request to the local tone state and queues the sample it yields.
  function automatic void synth_step(tone_req_t req);
    int                          active;
    longint                      sum;
    longint                      s;
    logic [PHASE_BITS-1:0]       ph;
    logic [COS_TABLE_BITS-1:0]   addr;
    case (req.op)
      OP_LOAD: begin
        gain[req.idx] = req.amp;
        incr[req.idx] = to_phase(req.step);
        offs[req.idx] = to_phase(req.offset);
      end
      OP_RESTART: begin
        foreach (ph_acc[j]) ph_acc[j] = '0;
      end
      OP_SAMPLE: begin
        active = (tones_enabled > MAX_TONES) ? MAX_TONES : int'(tones_enabled);
        sum = 0;
        for (int j = 0; j < active; j++) begin
          ph   = ph_acc[j] + offs[j];
          addr = ph[PHASE_BITS-1 -: COS_TABLE_BITS];
          sum  = sum + longint'(gain[j]) * longint'(wave_rom[addr]);
        end
        s = sum / 64'sd8388608;
        if (s > OUT_MAX) begin
          s = OUT_MAX;
        end
        if (s < OUT_MIN) begin
          s = OUT_MIN;
        end
        for (int j = 0; j < active; j++) begin
          ph_acc[j] = ph_acc[j] + incr[j];
        end
        expected_samples.push_back(OUT_W'(s));
      end
      default: begin
      end
    endcase
  endfunction

  task automatic flag_mismatch(string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void queue_req(logic [OP_W-1:0] op, logic [IDX_W-1:0] idx,
                                    logic [AMP_W-1:0] amp, logic [IN_PHASE_W-1:0] stp,
                                    logic [IN_PHASE_W-1:0] off);
    tone_req_t r;
    r.op     = op;
    r.idx    = idx;
    r.amp    = amp;
    r.step   = stp;
    r.offset = off;
    pending_reqs.push_back(r);
  endfunction

  function automatic void queue_noisy(logic [OP_W-1:0] op);
    queue_req(op, IDX_W'($urandom()), AMP_W'($urandom()), $urandom(), $urandom());
  endfunction

  function automatic logic [AMP_W-1:0] pick_amp();
    case ($urandom_range(3))
      0: return AMP_W'($urandom());
      1: return $urandom_range(1) ? {1'b0, {(AMP_W-1){1'b1}}} : {1'b1, {(AMP_W-1){1'b0}}};
      2: return AMP_W'($urandom_range(8191)) - AMP_W'(4096);
      default: return AMP_W'($urandom()) >> 1;
    endcase
  endfunction

  function automatic logic [IN_PHASE_W-1:0] pick_step();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(32'h03FF_FFFF);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'hFFFF_FFFF;
      default: return 32'h0;
    endcase
  endfunction

  task automatic queue_random_bursts(int target);
    int made;
    int nload;
    int nsamp;
    made = 0;
    @(negedge clk);
    while (made < target) begin
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(2))
          0: queue_noisy(OP_UNUSED);
          1: begin
            queue_noisy(OP_RESTART);
            made++;
          end
          default: begin
            queue_noisy(OP_SAMPLE);
            made++;
          end
        endcase
      end else begin
        nload = $urandom_range(3);
        for (int k = 0; k < nload; k++) begin
          queue_req(OP_LOAD, IDX_W'($urandom()), pick_amp(), pick_step(), $urandom());
        end
        if ($urandom_range(1)) begin
          queue_noisy(OP_RESTART);
        end
        nsamp = $urandom_range(2, 16);
        for (int k = 0; k < nsamp; k++) begin
          queue_noisy(OP_SAMPLE);
        end
        made += nload + nsamp;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_if.valid || expected_samples.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_tone_count(logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_if.valid      <= 1'b1;
    cfg_if.tone_count <= v;
    do @(posedge clk);
    while (!cfg_if.ready);
    tones_enabled = v;
    settings_written++;
    cfg_if.valid <= 1'b0;
  endtask

  task automatic set_idling(int mode);
    case (mode)
      0: begin
        in_gap_pct    = 0;
        out_stall_pct = 0;
      end
      1: begin
        in_gap_pct    = 54;
        out_stall_pct = 0;
      end
      2: begin
        in_gap_pct    = 0;
        out_stall_pct = 54;
      end
      default: begin
        in_gap_pct    = 16;
        out_stall_pct = 16;
      end
    endcase
  endtask

  always @(posedge clk) begin : drive_reqs
    tone_req_t nxt;
    tone_req_t got;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        got.op     = in_if.operation;
        got.idx    = in_if.tone_index;
        got.amp    = in_if.amplitude;
        got.step   = in_if.freq_step;
        got.offset = in_if.phase_offset;
        synth_step(got);
        reqs_accepted++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= in_gap_pct) begin
          nxt = pending_reqs.pop_front();
          in_if.valid        <= 1'b1;
          in_if.operation    <= nxt.op;
          in_if.tone_index   <= nxt.idx;
          in_if.amplitude    <= nxt.amp;
          in_if.freq_step    <= nxt.step;
          in_if.phase_offset <= nxt.offset;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_samples
    logic signed [OUT_W-1:0] want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_samples.size() == 0) begin
          flag_mismatch($sformatf("sample %0d arrived with none expected", out_if.sample));
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (out_if.sample !== want) begin
            flag_mismatch($sformatf("sample %0d, expected %0d", out_if.sample, want));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without progress.", quiet_cycles);
      $display("multi_tone_cosine_synthesizer_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : run
    int counts [NUM_PHASES];
    int per_phase;
    counts = '{15, 1, 3, 8, 0, 5, 9, 2, 7, 4, 6, 8, 12, 8};
    per_phase = RANDOM_REQS / NUM_PHASES;
    in_if.valid        = 1'b0;
    in_if.operation    = '0;
    in_if.tone_index   = '0;
    in_if.amplitude    = '0;
    in_if.freq_step    = '0;
    in_if.phase_offset = '0;
    out_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.tone_count  = '0;
    tones_enabled      = '0;
    error_count        = 0;
    reqs_accepted      = 0;
    samples_checked    = 0;
    settings_written   = 0;
    quiet_cycles       = 0;
    foreach (ph_acc[j]) begin
      ph_acc[j] = '0;
      gain[j]   = '0;
      incr[j]   = '0;
      offs[j]   = '0;
    end
    fill_wave_rom();
    set_idling(0);
    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // With no tones enabled a sample is zero; then every tone entry gets loaded.
    @(negedge clk);
    queue_noisy(OP_SAMPLE);
    queue_noisy(OP_UNUSED);
    queue_noisy(OP_RESTART);
    queue_req(OP_LOAD, 3'd0, 24'h7FFFFF, 32'h0000_0000, 32'h0000_0000);
    queue_req(OP_LOAD, 3'd1, 24'h800000, 32'h0000_0000, 32'h8000_0000);
    queue_req(OP_LOAD, 3'd2, 24'h000000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_req(OP_LOAD, 3'd3, 24'hFFFFFF, 32'h4000_0000, 32'h0000_0000);
    queue_req(OP_LOAD, 3'd4, 24'h000100, 32'h0000_0001, 32'h4000_0000);
    queue_req(OP_LOAD, 3'd5, 24'h7FFFFF, 32'h8000_0000, 32'hC000_0000);
    queue_req(OP_LOAD, 3'd6, 24'h800000, 32'h0040_0000, 32'h0020_0000);
    queue_req(OP_LOAD, 3'd7, 24'h123456, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    queue_noisy(OP_SAMPLE);
    wait_drained();

    write_tone_count(4'd8);
    set_idling(3);
    @(negedge clk);
    repeat (3) queue_noisy(OP_SAMPLE);
    queue_noisy(OP_RESTART);
    repeat (2) queue_noisy(OP_SAMPLE);
    queue_noisy(OP_UNUSED);
    queue_req(OP_LOAD, 3'd2, 24'h7FFFFF, 32'h0000_0000, 32'h0000_0000);
    queue_noisy(OP_SAMPLE);
    wait_drained();

    for (int p = 0; p < NUM_PHASES; p++) begin
      set_idling(p % 4);
      write_tone_count(CNT_W'(counts[p]));
      queue_random_bursts(per_phase / 2);
      // The sender holds off here until every queued sample is back.
      wait_drained();
      queue_random_bursts(per_phase - per_phase / 2);
      wait_drained();
    end

    if (expected_samples.size() != 0) begin
      flag_mismatch($sformatf("%0d samples never arrived", expected_samples.size()));
    end
    $display("Covered %0d requests and %0d checked samples across %0d tone-count settings,",
             reqs_accepted, samples_checked, settings_written);
    $display("with loads, restarts, ignored opcodes and four idling patterns; %0d errors.",
             error_count);
    if (error_count == 0) begin
      $display("multi_tone_cosine_synthesizer_unit regression: pass");
    end else begin
      $display("multi_tone_cosine_synthesizer_unit regression: fail");
    end
    $finish;
  end

endmodule
